// ----- rtl/bpa_pkg.sv -----
package bpa_pkg;

    // Widths of the request and response fields
    localparam int unsigned SIZE_W     = 32;
    localparam int unsigned IO_POOL_W  = 8;
    localparam int unsigned IO_OFF_W   = 32;
    localparam int unsigned STATUS_W   = 3;

    // Defaults for the top level parameters
    localparam int unsigned FREE_SLOTS_DEF  = 16;
    localparam int unsigned OFFSET_BITS_DEF = 32;
    localparam int unsigned POOL_BITS_DEF   = 8;

    // Pool size after reset
    localparam logic [SIZE_W-1:0] POOL_BYTES_RESET = 32'd409600000;

    typedef enum logic
    {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } op_t;

    typedef enum logic [STATUS_W-1:0]
    {
        ST_BUMPED    = 3'd0,
        ST_REUSED    = 3'd1,
        ST_NEWPOOL   = 3'd2,
        ST_RECORDED  = 3'd3,
        ST_DUPLICATE = 3'd4,
        ST_FULL      = 3'd5,
        ST_REFUSED   = 3'd6
    } status_t;

    typedef struct packed
    {
        op_t                   opcode;
        logic [SIZE_W-1:0]     block_size;
        logic [IO_POOL_W-1:0]  block_pool;
        logic [IO_OFF_W-1:0]   block_offset;
    } req_t;

    typedef struct packed
    {
        logic [IO_POOL_W-1:0]  result_pool;
        logic [IO_OFF_W-1:0]   result_offset;
        status_t               status;
    } rsp_t;

    // Control flags of the scan token walking down the slot chain
    typedef struct packed
    {
        logic active;
        logic hit;
        logic empty_hit;
    } tok_ctl_t;

endpackage

// ----- rtl/bump_pool_allocator_free_table_top.sv -----
// Pool allocator with an exact-fit table of freed blocks.
//
// Request channel: drive request and pulse start while busy is low; the
// request is taken at that edge and busy rises the next cycle. Allocate
// requests reuse the lowest table entry of equal size, otherwise carve from
// the current pool (opening the next pool when the head would reach the
// limit, refused if neither fits). A new free fills the lowest empty entry.
// Response channel: done is high for exactly one cycle with response valid;
// the receiver cannot stall, so the response must be captured then.
// Configuration: cfg_we writes cfg_data into the pool size register; write
// only while busy is low and no response is pending.
// Sequencing: one request is in flight at a time, as start is taken only
// while busy is low. A scan token walks the chain of FREE_SLOTS slot cells
// one cell per cycle; launch_reg starts it, and the outcome is resolved and
// the pool state updated as it leaves the last cell.
// Reset: asynchronous, active low; the table is empty, head and pool are
// zero and the pool size returns to 409600000 bytes.
module bump_pool_allocator_free_table_top #(
    parameter int unsigned FREE_SLOTS  = bpa_pkg::FREE_SLOTS_DEF,
    parameter int unsigned OFFSET_BITS = bpa_pkg::OFFSET_BITS_DEF,
    parameter int unsigned POOL_BITS   = bpa_pkg::POOL_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  bpa_pkg::req_t               request,
    output logic                        done,
    output bpa_pkg::rsp_t               response,
    input  logic                        cfg_we,
    input  logic [bpa_pkg::SIZE_W-1:0]  cfg_data
);
    import bpa_pkg::*;

    localparam int unsigned IDX_W   = $clog2(FREE_SLOTS);
    localparam int unsigned PLACE_W = POOL_BITS + OFFSET_BITS;
    localparam int unsigned LIM_W   = ((OFFSET_BITS > SIZE_W) ? OFFSET_BITS : SIZE_W) + 1;
    localparam logic [LIM_W-1:0] LIM_CAP   = LIM_W'(1) << OFFSET_BITS;
    localparam logic [LIM_W-1:0] LIM_RESET =
        (LIM_W'(POOL_BYTES_RESET) > LIM_CAP) ? LIM_CAP : LIM_W'(POOL_BYTES_RESET);

    typedef enum logic
    {
        S_IDLE,
        S_SCAN
    } state_t;

    state_t                  state_reg;
    state_t                  state_next;
    logic                    launch_reg;
    logic                    done_reg;
    logic                    done_next;
    rsp_t                    rsp_reg;
    rsp_t                    rsp_next;
    logic [LIM_W-1:0]        lim_reg;
    logic [LIM_W-1:0]        lim_next;
    logic [OFFSET_BITS-1:0]  head_reg;
    logic [OFFSET_BITS-1:0]  head_next;
    logic [POOL_BITS-1:0]    pool_reg;
    logic [POOL_BITS-1:0]    pool_next;
    op_t                     req_op_reg;
    logic [SIZE_W-1:0]       req_size_reg;
    logic [PLACE_W-1:0]      req_place_reg;

    logic                    accept;
    logic                    finish;
    logic                    wr_en;
    logic [LIM_W-1:0]        sum;
    logic [LIM_W-1:0]        size_ext;
    logic [POOL_BITS-1:0]    hit_pool;
    logic [OFFSET_BITS-1:0]  hit_off;
    logic [POOL_BITS-1:0]    pool_inc;

    tok_ctl_t                tok_ctl   [FREE_SLOTS+1];
    logic [PLACE_W-1:0]      tok_place [FREE_SLOTS+1];
    logic [IDX_W-1:0]        tok_idx   [FREE_SLOTS+1];

    assign accept = start && (state_reg == S_IDLE);
    assign busy   = (state_reg != S_IDLE);
    assign finish = (state_reg == S_SCAN) && tok_ctl[FREE_SLOTS].active;

    // Launch a fresh token into the first cell
    assign tok_ctl[0]   = '{active: launch_reg, hit: 1'b0, empty_hit: 1'b0};
    assign tok_place[0] = '0;
    assign tok_idx[0]   = '0;

    // Slot cell chain
    for (genvar g = 0; g < FREE_SLOTS; g++)
    begin : g_cell
        bpa_cell #(
            .SLOT_IDX (g),
            .IDX_W    (IDX_W),
            .PLACE_W  (PLACE_W)
        ) u_cell (
            .clk           (clk),
            .rst_n         (rst_n),
            .opcode        (req_op_reg),
            .req_size      (req_size_reg),
            .req_place     (req_place_reg),
            .wr_en         (wr_en),
            .wr_idx        (tok_idx[FREE_SLOTS]),
            .tok_in        (tok_ctl[g]),
            .tok_place_in  (tok_place[g]),
            .tok_idx_in    (tok_idx[g]),
            .tok_out       (tok_ctl[g+1]),
            .tok_place_out (tok_place[g+1]),
            .tok_idx_out   (tok_idx[g+1])
        );
    end

    // Clip the configured pool size to the offset range
    assign lim_next = (LIM_W'(cfg_data) > LIM_CAP) ? LIM_CAP : LIM_W'(cfg_data);

    assign size_ext = LIM_W'(req_size_reg);
    assign sum      = LIM_W'(head_reg) + size_ext;
    assign hit_pool = tok_place[FREE_SLOTS][PLACE_W-1:OFFSET_BITS];
    assign hit_off  = tok_place[FREE_SLOTS][OFFSET_BITS-1:0];
    assign pool_inc = pool_reg + POOL_BITS'(1);

    // Record a free in the first empty slot found by the token
    assign wr_en = finish && (req_op_reg == OP_FREE) && !tok_ctl[FREE_SLOTS].hit
                   && tok_ctl[FREE_SLOTS].empty_hit;

    // Resolve the request once the token leaves the last cell
    always_comb
    begin
        state_next = state_reg;
        done_next  = 1'b0;
        rsp_next   = rsp_reg;
        head_next  = head_reg;
        pool_next  = pool_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (finish)
                begin
                    state_next = S_IDLE;
                    done_next  = 1'b1;
                    rsp_next   = '{result_pool: '0, result_offset: '0, status: ST_REFUSED};
                    if (req_op_reg == OP_ALLOC)
                    begin
                        if (tok_ctl[FREE_SLOTS].hit)
                        begin
                            rsp_next.result_pool   = IO_POOL_W'(hit_pool);
                            rsp_next.result_offset = IO_OFF_W'(hit_off);
                            rsp_next.status        = ST_REUSED;
                        end
                        else if (size_ext > lim_reg)
                        begin
                            rsp_next.status = ST_REFUSED;
                        end
                        else if (sum >= lim_reg)
                        begin
                            if (pool_reg != '1)
                            begin
                                pool_next            = pool_inc;
                                head_next            = OFFSET_BITS'(req_size_reg);
                                rsp_next.result_pool = IO_POOL_W'(pool_inc);
                                rsp_next.status      = ST_NEWPOOL;
                            end
                        end
                        else
                        begin
                            head_next              = OFFSET_BITS'(sum);
                            rsp_next.result_pool   = IO_POOL_W'(pool_reg);
                            rsp_next.result_offset = IO_OFF_W'(head_reg);
                            rsp_next.status        = ST_BUMPED;
                        end
                    end
                    else if (tok_ctl[FREE_SLOTS].hit)
                    begin
                        rsp_next.status = ST_DUPLICATE;
                    end
                    else if (!tok_ctl[FREE_SLOTS].empty_hit)
                    begin
                        rsp_next.status = ST_FULL;
                    end
                    else
                    begin
                        rsp_next.status = ST_RECORDED;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold state, pool bookkeeping and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            launch_reg <= 1'b0;
            done_reg   <= 1'b0;
            rsp_reg    <= '{result_pool: '0, result_offset: '0, status: ST_BUMPED};
            lim_reg    <= LIM_RESET;
            head_reg   <= '0;
            pool_reg   <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            launch_reg <= accept;
            done_reg   <= done_next;
            rsp_reg    <= rsp_next;
            head_reg   <= head_next;
            pool_reg   <= pool_next;
            if (cfg_we)
            begin
                lim_reg <= lim_next;
            end
        end
    end

    // Latch the request, masking pool and offset to the configured widths
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_op_reg    <= request.opcode;
            req_size_reg  <= request.block_size;
            req_place_reg <= {POOL_BITS'(request.block_pool),
                              OFFSET_BITS'(request.block_offset)};
        end
    end

    assign done     = done_reg;
    assign response = rsp_reg;

    a_result_timing: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##(FREE_SLOTS+2) done)
        else $error("response strobe missing after scan");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("response while a request is in flight");

    a_token_scan: assert property (@(posedge clk) disable iff (!rst_n)
        tok_ctl[FREE_SLOTS].active |-> (state_reg == S_SCAN))
        else $error("scan token out of place");

    a_write_free: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |=> (done && response.status == ST_RECORDED))
        else $error("slot written without a recorded free");

endmodule

// ----- rtl/bpa_cell.sv -----
module bpa_cell #(
    parameter int unsigned SLOT_IDX = 0,
    parameter int unsigned IDX_W    = 4,
    parameter int unsigned PLACE_W  = 40
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  bpa_pkg::op_t                  opcode,
    input  logic [bpa_pkg::SIZE_W-1:0]    req_size,
    input  logic [PLACE_W-1:0]            req_place,
    input  logic                          wr_en,
    input  logic [IDX_W-1:0]              wr_idx,
    input  bpa_pkg::tok_ctl_t             tok_in,
    input  logic [PLACE_W-1:0]            tok_place_in,
    input  logic [IDX_W-1:0]              tok_idx_in,
    output bpa_pkg::tok_ctl_t             tok_out,
    output logic [PLACE_W-1:0]            tok_place_out,
    output logic [IDX_W-1:0]              tok_idx_out
);
    import bpa_pkg::*;

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(SLOT_IDX);

    logic                valid_reg;
    logic                valid_next;
    logic [PLACE_W-1:0]  place_reg;
    logic [SIZE_W-1:0]   size_reg;
    logic                match;
    logic                take;
    logic                wr_here;
    tok_ctl_t            tok_ctl_reg;
    tok_ctl_t            tok_ctl_next;
    logic [PLACE_W-1:0]  tok_place_reg;
    logic [PLACE_W-1:0]  tok_place_next;
    logic [IDX_W-1:0]    tok_idx_reg;
    logic [IDX_W-1:0]    tok_idx_next;

    // Compare this slot against the request: size on allocate, place on free
    assign match   = valid_reg && ((opcode == OP_FREE) ? (place_reg == req_place)
                                                        : (size_reg == req_size));
    assign take    = tok_in.active && (opcode == OP_ALLOC) && match && !tok_in.hit;
    assign wr_here = wr_en && (wr_idx == MY_IDX);

    // Update the token as it passes this slot
    always_comb
    begin
        tok_ctl_next   = tok_in;
        tok_place_next = tok_place_in;
        tok_idx_next   = tok_idx_in;
        if (tok_in.active)
        begin
            tok_ctl_next.hit = tok_in.hit | match;
            if (take)
            begin
                tok_place_next = place_reg;
            end
            if (!valid_reg && !tok_in.empty_hit)
            begin
                tok_ctl_next.empty_hit = 1'b1;
                tok_idx_next           = MY_IDX;
            end
        end
    end

    // Set on record, drop on reuse
    always_comb
    begin
        valid_next = valid_reg;
        if (wr_here)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= 1'b0;
            tok_ctl_reg <= '0;
        end
        else
        begin
            valid_reg   <= valid_next;
            tok_ctl_reg <= tok_ctl_next;
        end
    end

    // Hold slot contents and token payload
    always_ff @(posedge clk)
    begin
        if (wr_here)
        begin
            place_reg <= req_place;
            size_reg  <= req_size;
        end
        tok_place_reg <= tok_place_next;
        tok_idx_reg   <= tok_idx_next;
    end

    assign tok_out       = tok_ctl_reg;
    assign tok_place_out = tok_place_reg;
    assign tok_idx_out   = tok_idx_reg;

endmodule
